// ===== rtl/gtd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register codes, reset values and types of the Goertzel tone detector.
// No dependencies; every other file of the block imports this package.
package gtd_pkg;

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 18;
    localparam int TAP_W    = 48;
    localparam int MAG_W    = 63;
    localparam int LEN_W    = 11;

    // Register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_COEFF = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COS   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIN   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEN   = 2'd3;

    localparam logic signed [COEF_W-1:0] RESET_COEFF = 18'sd97180;
    localparam logic signed [COEF_W-1:0] RESET_COS   = 18'sd48590;
    localparam logic signed [COEF_W-1:0] RESET_SIN   = 18'sd43977;
    localparam logic [LEN_W-1:0]         RESET_LEN   = 11'd205;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic signed [COEF_W-1:0] coeff;
        logic signed [COEF_W-1:0] cos_val;
        logic signed [COEF_W-1:0] sin_val;
        logic [LEN_W-1:0]         block_len;
    } gtd_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } gtd_item_t;

endpackage

// ===== rtl/gtd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples in and bin results out.
// Depends on gtd_pkg for field widths.
interface gtd_sample_if import gtd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface gtd_result_if import gtd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [TAP_W-1:0] real_part;
    logic signed [TAP_W-1:0] imag_part;
    logic [MAG_W-1:0]        magnitude_squared;

    modport source (output valid, output real_part, output imag_part,
                    output magnitude_squared, input ready);
    modport sink (input valid, input real_part, input imag_part,
                  input magnitude_squared, output ready);
endinterface

// ===== rtl/gtd_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers: coefficient, cosine, sine and block length.
// Depends on gtd_pkg.
module gtd_regs import gtd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output gtd_cfg_t              cfg
);

    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;
    gtd_cfg_t             cfg_reg;
    gtd_cfg_t             cfg_next;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COEFF: cfg_next.coeff     = signed'(pwdata[COEF_W-1:0]);
                REG_COS:   cfg_next.cos_val   = signed'(pwdata[COEF_W-1:0]);
                REG_SIN:   cfg_next.sin_val   = signed'(pwdata[COEF_W-1:0]);
                REG_LEN:   cfg_next.block_len = pwdata[LEN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{coeff: RESET_COEFF, cos_val: RESET_COS,
                         sin_val: RESET_SIN, block_len: RESET_LEN};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Readback, coefficients sign-extended
    always_comb
    begin
        unique case (idx)
            REG_COEFF: prdata = APB_DATA_W'(cfg_reg.coeff);
            REG_COS:   prdata = APB_DATA_W'(cfg_reg.cos_val);
            REG_SIN:   prdata = APB_DATA_W'(cfg_reg.sin_val);
            REG_LEN:   prdata = APB_DATA_W'(cfg_reg.block_len);
        endcase
    end

endmodule

// ===== rtl/gtd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, counts them against the block length and marks
// the sample that closes each block. Depends on gtd_pkg and gtd_if.
module gtd_front import gtd_pkg::*; #(
    parameter int MAX_BLOCK_LENGTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  gtd_cfg_t    cfg,
    gtd_sample_if.sink  samples,
    input  logic        full,
    output logic        push,
    output gtd_item_t   push_item
);

    localparam int CNT_W = $clog2(MAX_BLOCK_LENGTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] len_eff;
    logic             last;

    // Effective block length: zero acts as one, long values clamp to the maximum
    always_comb
    begin
        priority if (cfg.block_len == '0)
            len_eff = CNT_W'(1);
        else if (32'(cfg.block_len) > 32'(MAX_BLOCK_LENGTH))
            len_eff = CNT_W'(MAX_BLOCK_LENGTH);
        else
            len_eff = CNT_W'(cfg.block_len);
    end

    assign samples.ready = !full;
    assign push          = samples.valid && !full;
    assign count_inc     = count_reg + 1'b1;
    assign last          = (count_inc >= len_eff);

    assign push_item.sample = samples.sample;
    assign push_item.last   = last;

    // Sample counter, cleared by the block-ending transfer
    always_comb
    begin
        count_next = count_reg;
        if (push)
            count_next = last ? '0 : count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// ===== rtl/gtd_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified samples between the front end and the datapath.
// Depends on gtd_pkg.
module gtd_queue import gtd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gtd_item_t push_item,
    output logic      full,
    input  logic      pop,
    output gtd_item_t head,
    output logic      empty
);

    gtd_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    assign full  = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill level out of range");

endmodule

// ===== rtl/gtd_back.sv =====
`timescale 1ns / 1ps
// Datapath: runs the recurrence and the end-of-block bin terms on one shared
// multiplier over split operands, and holds the result register. Depends on gtd_pkg, gtd_if.
module gtd_back import gtd_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gtd_cfg_t      cfg,
    input  logic          empty,
    input  gtd_item_t     head,
    output logic          pop,
    gtd_result_if.source  results
);

    // Operands cover the taps and the scaled product tap*coeff
    localparam int PROD_W = TAP_W + COEF_W;
    localparam int OP_W   = (PROD_W - FRACTION_BITS > TAP_W) ? PROD_W - FRACTION_BITS : TAP_W;
    localparam int PW     = (OP_W + 1) / 2;
    localparam int MUL_W  = 2 * PW + 2;
    localparam int ACC_W  = 4 * PW + 4;
    localparam int F2     = 2 * FRACTION_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_POST = 2'd3;

    localparam logic [2:0] PH_REC  = 3'd0;
    localparam logic [2:0] PH_T    = 3'd1;
    localparam logic [2:0] PH_REAL = 3'd2;
    localparam logic [2:0] PH_IMAG = 3'd3;
    localparam logic [2:0] PH_MAG1 = 3'd4;
    localparam logic [2:0] PH_MAG2 = 3'd5;
    localparam logic [2:0] PH_MAG3 = 3'd6;

    logic [1:0]              state_reg, state_next;
    logic [2:0]              phase_reg, phase_next;
    logic [1:0]              piece_reg, piece_next;
    logic [SAMPLE_W-1:0]     smp_reg;
    logic                    last_reg;
    logic signed [TAP_W-1:0] tap1_reg, tap1_next;
    logic signed [TAP_W-1:0] tap2_reg, tap2_next;
    logic signed [OP_W-1:0]  t_reg;
    logic signed [TAP_W-1:0] real_reg;
    logic signed [TAP_W-1:0] imag_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [MUL_W-1:0] pp_reg;
    logic                    pp_vld_reg;
    logic                    pp_neg_reg;
    logic                    pp_clr_reg;
    logic [1:0]              pp_sh_reg;
    logic                    out_valid_reg;
    logic signed [TAP_W-1:0] out_real_reg;
    logic signed [TAP_W-1:0] out_imag_reg;
    logic [MAG_W-1:0]        out_mag_reg;

    logic signed [OP_W-1:0]   a_op, b_op;
    logic signed [2*PW-1:0]   a_ext, b_ext;
    logic signed [PW:0]       mul_a, mul_b;
    logic signed [MUL_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]  pp_ext, term;
    logic signed [ACC_W-1:0]  acc_sh1, smp_term, rec_sum, real_sum, mag_sh;
    logic [MAG_W-1:0]         mag_val;
    logic                     out_free;
    logic                     out_load;

    // Saturate a wide value to a 48-bit tap
    function automatic logic signed [TAP_W-1:0] sat_tap(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-TAP_W:0] top;
        top = x[ACC_W-1:TAP_W-1];
        if ((&top) || !(|top))
            return x[TAP_W-1:0];
        else if (x[ACC_W-1])
            return {1'b1, {(TAP_W-1){1'b0}}};
        else
            return {1'b0, {(TAP_W-1){1'b1}}};
    endfunction

    // Operand select per product
    always_comb
    begin
        unique case (phase_reg)
            PH_REC, PH_T:
            begin
                a_op = OP_W'(tap1_reg);
                b_op = OP_W'(cfg.coeff);
            end
            PH_REAL:
            begin
                a_op = OP_W'(tap2_reg);
                b_op = OP_W'(cfg.cos_val);
            end
            PH_IMAG:
            begin
                a_op = OP_W'(tap2_reg);
                b_op = OP_W'(cfg.sin_val);
            end
            PH_MAG1:
            begin
                a_op = OP_W'(tap1_reg);
                b_op = OP_W'(tap1_reg);
            end
            PH_MAG2:
            begin
                a_op = OP_W'(tap2_reg);
                b_op = OP_W'(tap2_reg);
            end
            PH_MAG3:
            begin
                a_op = OP_W'(tap2_reg);
                b_op = t_reg;
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // Split into unsigned low and signed high halves; one partial product a cycle
    always_comb
    begin
        a_ext = (2*PW)'(a_op);
        b_ext = (2*PW)'(b_op);
        mul_a = piece_reg[0] ? $signed({a_ext[2*PW-1], a_ext[2*PW-1:PW]})
                             : $signed({1'b0, a_ext[PW-1:0]});
        mul_b = piece_reg[1] ? $signed({b_ext[2*PW-1], b_ext[2*PW-1:PW]})
                             : $signed({1'b0, b_ext[PW-1:0]});
        mul_p = mul_a * mul_b;
    end

    // Accumulate the registered partial product at its weight
    always_comb
    begin
        pp_ext = ACC_W'(pp_reg);
        unique case (pp_sh_reg)
            2'd0:    term = pp_ext;
            2'd1:    term = pp_ext <<< PW;
            default: term = pp_ext <<< (2 * PW);
        endcase
        if (pp_neg_reg)
            term = -term;
        acc_next = acc_reg;
        if (pp_vld_reg)
            acc_next = (pp_clr_reg ? '0 : acc_reg) + term;
    end

    // Post-processing of the settled accumulator
    always_comb
    begin
        acc_sh1  = acc_reg >>> FRACTION_BITS;
        smp_term = ACC_W'($signed({1'b0, smp_reg})) <<< FRACTION_BITS;
        rec_sum  = acc_sh1 - ACC_W'(tap2_reg) + smp_term;
        real_sum = ACC_W'(tap1_reg) - acc_sh1;
        mag_sh   = acc_reg >>> F2;
        priority if (mag_sh[ACC_W-1])
            mag_val = '0;
        else if (|mag_sh[ACC_W-2:MAG_W])
            mag_val = '1;
        else
            mag_val = mag_sh[MAG_W-1:0];
    end

    assign out_free = !out_valid_reg || results.ready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        piece_next = piece_reg;
        tap1_next  = tap1_reg;
        tap2_next  = tap2_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_MUL;
                    phase_next = PH_REC;
                    piece_next = '0;
                end
            end
            ST_MUL:
            begin
                piece_next = piece_reg + 2'd1;
                if (piece_reg == 2'd3)
                begin
                    if (phase_reg == PH_MAG1 || phase_reg == PH_MAG2)
                        phase_next = phase_reg + 3'd1;
                    else
                        state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_POST;
            end
            ST_POST:
            begin
                unique case (phase_reg)
                    PH_REC:
                    begin
                        tap2_next = tap1_reg;
                        tap1_next = sat_tap(rec_sum);
                        if (last_reg)
                        begin
                            phase_next = PH_T;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    PH_T:
                    begin
                        phase_next = PH_REAL;
                        state_next = ST_MUL;
                    end
                    PH_REAL:
                    begin
                        phase_next = PH_IMAG;
                        state_next = ST_MUL;
                    end
                    PH_IMAG:
                    begin
                        phase_next = PH_MAG1;
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            tap1_next  = '0;
                            tap2_next  = '0;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
        endcase
    end

    // Control state and taps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_REC;
            piece_reg     <= '0;
            tap1_reg      <= '0;
            tap2_reg      <= '0;
            pp_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            piece_reg  <= piece_next;
            tap1_reg   <= tap1_next;
            tap2_reg   <= tap2_next;
            pp_vld_reg <= (state_reg == ST_MUL);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pp_reg     <= mul_p;
        pp_sh_reg  <= {1'b0, piece_reg[0]} + {1'b0, piece_reg[1]};
        pp_neg_reg <= (phase_reg == PH_MAG3);
        pp_clr_reg <= (piece_reg == 2'd0) && (phase_reg != PH_MAG2) && (phase_reg != PH_MAG3);
        acc_reg    <= acc_next;
        if (pop)
        begin
            smp_reg  <= head.sample;
            last_reg <= head.last;
        end
        if (state_reg == ST_POST && phase_reg == PH_T)
            t_reg <= acc_sh1[OP_W-1:0];
        if (state_reg == ST_POST && phase_reg == PH_REAL)
            real_reg <= sat_tap(real_sum);
        if (state_reg == ST_POST && phase_reg == PH_IMAG)
            imag_reg <= sat_tap(acc_sh1);
        if (out_load)
        begin
            out_real_reg <= real_reg;
            out_imag_reg <= imag_reg;
            out_mag_reg  <= mag_val;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.real_part         = out_real_reg;
    assign results.imag_part         = out_imag_reg;
    assign results.magnitude_squared = out_mag_reg;

    a_result_only_at_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> last_reg)
        else $error("result produced for a sample that does not end a block");

    a_taps_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (tap1_reg == '0 && tap2_reg == '0))
        else $error("taps not cleared after block result");

    a_acc_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST) |-> !pp_vld_reg)
        else $error("accumulator still collecting during post-processing");

    a_pop_starts_rec: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_MUL && phase_reg == PH_REC && piece_reg == 2'd0))
        else $error("dequeued sample did not start the recurrence");

endmodule

// ===== rtl/goertzel_tone_detector_unit.sv =====
`timescale 1ns / 1ps
// Single-bin Goertzel tone detector: samples in over a valid/ready channel,
// one bin result out per block. Depends on gtd_pkg, gtd_if, gtd_regs,
// gtd_front, gtd_queue and gtd_back.
//
// Each 8-bit sample advances the recurrence q0 = coeff*q1 - q2 + sample; after
// block_length samples the block delivers real part, imaginary part and
// magnitude squared, then clears its taps. All products are exact and go
// through one shared multiplier working on halves of the operands, four
// partial products per product. Every sample runs the recurrence in the
// datapath; the sample that closes a block then adds the scaled tap product,
// real part, imaginary part and the three magnitude terms, and the block
// waits while the sink has not taken the previous result. A four-entry
// queue decouples sample transfers from the datapath, and the result register
// lets the datapath continue with the next block while a result waits.
// Registers (APB, byte address 4*i): 0 recurrence_coeff, 1 cosine_value,
// 2 sine_value (signed Q2.FRACTION_BITS), 3 block_length. Write them only
// while the block is idle.
module goertzel_tone_detector_unit import gtd_pkg::*; #(
    parameter int MAX_BLOCK_LENGTH = 1024,
    parameter int FRACTION_BITS    = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    gtd_sample_if.sink            samples,
    gtd_result_if.source          results
);

    gtd_cfg_t  cfg;
    logic      push;
    gtd_item_t push_item;
    logic      full;
    logic      pop;
    gtd_item_t head;
    logic      empty;

    gtd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtd_front #(
        .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .samples   (samples),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    gtd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    gtd_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .empty   (empty),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule
